// ===== hw/rtl/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int FLT_BIAS      = 127;
  localparam int FLT_MAN_W     = 23;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_SUB     = 5'd1,
    OP_MUL     = 5'd2,
    OP_DIV     = 5'd3,
    OP_EQ      = 5'd4,
    OP_GT      = 5'd5,
    OP_LT      = 5'd6,
    OP_GE      = 5'd7,
    OP_LE      = 5'd8,
    OP_MIN     = 5'd9,
    OP_MAX     = 5'd10,
    OP_INC     = 5'd11,
    OP_DEC     = 5'd12,
    OP_INT2FIX = 5'd13,
    OP_FIX2INT = 5'd14,
    OP_FLT2FIX = 5'd15,
    OP_FIX2FLT = 5'd16
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] fout;
    logic              flag;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic valid;
    logic is_div;
  } tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fixed_point_q24_8_alu_unit.sv =====
// Top level of the Q24.8 fixed-point ALU: input stage, datapaths, output stage.
// The divider sets the pipeline depth, with one quotient bit per stage.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat is stalled. Reset (synchronous, active high) clears all valid bits
// and the alignment taps; the other data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu_unit
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [4:0]               opcode,
  input  wire logic signed [DATA_W-1:0] operand_a,
  input  wire logic signed [DATA_W-1:0] operand_b,
  input  wire logic [DATA_W-1:0]        float_in,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic signed [DATA_W-1:0] result,
  output      logic [DATA_W-1:0]        float_out,
  output      logic                     flag,
  output      logic [1:0]               status
);

  localparam int DW    = DATA_W + FRAC_BITS;
  localparam int DLY   = DW - 2;
  localparam int DLY_W = $bits(tag_t) + $bits(res_t);

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // input stage
  logic                     s1_valid;
  logic [4:0]               s1_op;
  logic signed [DATA_W-1:0] s1_a;
  logic signed [DATA_W-1:0] s1_b;
  logic [DATA_W-1:0]        s1_flt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op  <= opcode;
      s1_a   <= operand_a;
      s1_b   <= operand_b;
      s1_flt <= float_in;
    end
  end

  tag_t s1_tag;
  assign s1_tag.valid  = s1_valid;
  assign s1_tag.is_div = (op_t'(s1_op) == OP_DIV);

  tag_t conv_tag;
  res_t conv_res;

  fpa_conv #(.FRAC_BITS(FRAC_BITS)) u_conv (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .tag_in  (s1_tag),
    .op      (s1_op),
    .a       (s1_a),
    .b       (s1_b),
    .flt     (s1_flt),
    .tag_out (conv_tag),
    .res_out (conv_res)
  );

  logic [DATA_W-1:0] div_q;
  logic              div_neg;
  logic              div_dz;

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .en   (adv),
    .a    (s1_a),
    .b    (s1_b),
    .quot (div_q),
    .neg  (div_neg),
    .dz   (div_dz)
  );

  logic [DLY_W-1:0] dly_out;
  tag_t             al_tag;
  res_t             al_res;

  fpa_delay #(.WIDTH(DLY_W), .DEPTH(DLY)) u_align (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .din  ({conv_tag, conv_res}),
    .dout (dly_out)
  );

  assign {al_tag, al_res} = dly_out;

  // output stage
  res_t merged;

  always_comb begin
    merged = al_res;
    if (al_tag.is_div) begin
      merged = '0;
      if (div_dz) merged.status = ST_DIVZ;
      else merged.res = div_neg ? DATA_W'(-div_q) : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= al_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result    <= merged.res;
      float_out <= merged.fout;
      flag      <= merged.flag;
      status    <= merged.status;
    end
  end

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DIVZ |-> result == '0 && float_out == '0)
    else $error("divide by zero beat carries a nonzero value");

  a_flag_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag |-> result == '0 && float_out == '0 && status == ST_OK)
    else $error("comparison beat carries other fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_sat_no_float: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SAT |-> float_out == '0)
    else $error("saturated conversion drives float output");

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_delay.sv =====
// Enabled shift line that aligns the short datapath with the divider.
`timescale 1ns / 1ps
`default_nettype none
module fpa_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output      logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output      logic        [DATA_W-1:0] quot,
  output      logic                     neg,
  output      logic                     dz
);

  localparam int DW = DATA_W + FRAC_BITS;

  logic [DATA_W-1:0] rem   [DW+1];
  logic [DW-1:0]     nq    [DW+1];
  logic [DATA_W-1:0] dd    [DW+1];
  logic              neg_s [DW+1];
  logic              dz_s  [DW+1];

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  assign mag_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign mag_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);

  // setup stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= '0;
      nq[0]    <= {mag_a, {FRAC_BITS{1'b0}}};
      dd[0]    <= mag_b;
      neg_s[0] <= a[DATA_W-1] ^ b[DATA_W-1];
      dz_s[0]  <= (b == '0);
    end
  end

  for (genvar g = 0; g < DW; g++) begin : g_step
    logic [DATA_W:0]   trial;
    logic              ge;
    logic [DATA_W-1:0] rem_next;

    assign trial    = {rem[g], nq[g][DW-1]};
    assign ge       = trial >= {1'b0, dd[g]};
    assign rem_next = ge ? DATA_W'(trial - {1'b0, dd[g]}) : trial[DATA_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]   <= rem_next;
        nq[g+1]    <= {nq[g][DW-2:0], ge};
        dd[g+1]    <= dd[g];
        neg_s[g+1] <= neg_s[g];
        dz_s[g+1]  <= dz_s[g];
      end
    end
  end

  assign quot = nq[DW][DATA_W-1:0];
  assign neg  = neg_s[DW];
  assign dz   = dz_s[DW];

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_conv.sv =====
// Three-stage datapath: simple ops, multiply and the float conversions.
`timescale 1ns / 1ps
`default_nettype none
module fpa_conv
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire tag_t                     tag_in,
  input  wire logic [4:0]               op,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  input  wire logic [DATA_W-1:0]        flt,
  output      tag_t                     tag_out,
  output      res_t                     res_out
);

  localparam logic signed [10:0] E_OFS   = 11'(FLT_BIAS + FLT_MAN_W - FRAC_BITS);
  localparam logic [9:0]         EXP_OFS = 10'(FLT_BIAS - FRAC_BITS);

  // stage 1
  tag_t                     c1_tag;
  op_t                      c1_op;
  res_t                     c1_res;
  logic signed [2*DATA_W-1:0] c1_prod;
  logic                     c1_fsign;
  logic [33:0]              c1_fmag;
  logic                     c1_fsat;
  logic                     c1_fnan;
  logic                     c1_xsign;
  logic                     c1_xzero;
  logic [DATA_W-1:0]        c1_xmag;

  res_t              s1_res;
  logic [7:0]        ex;
  logic [33:0]       mm;
  logic signed [10:0] e;
  logic [10:0]       neg_e;
  logic [33:0]       f_mag;
  logic              f_sat;
  logic              f_nan;

  always_comb begin
    s1_res = '0;
    case (op_t'(op))
      OP_ADD:     s1_res.res = DATA_W'(a + b);
      OP_SUB:     s1_res.res = DATA_W'(a - b);
      OP_EQ:      s1_res.flag = (a == b);
      OP_GT:      s1_res.flag = (a > b);
      OP_LT:      s1_res.flag = (a < b);
      OP_GE:      s1_res.flag = (a >= b);
      OP_LE:      s1_res.flag = (a <= b);
      OP_MIN:     s1_res.res = (a < b) ? a : b;
      OP_MAX:     s1_res.res = (a > b) ? a : b;
      OP_INC:     s1_res.res = DATA_W'(a + 32'sd1);
      OP_DEC:     s1_res.res = DATA_W'(a - 32'sd1);
      OP_INT2FIX: s1_res.res = a <<< FRAC_BITS;
      OP_FIX2INT: s1_res.res = a >>> FRAC_BITS;
      default:    s1_res = '0;
    endcase
  end

  always_comb begin
    ex    = flt[30:23];
    mm    = {10'd0, 1'b1, flt[22:0]};
    e     = $signed({3'b000, ex}) - E_OFS;
    neg_e = 11'(-e);
    f_mag = '0;
    f_sat = 1'b0;
    f_nan = 1'b0;
    if (ex == 8'hFF) begin
      f_nan = (flt[22:0] != '0);
      f_sat = (flt[22:0] == '0);
    end else if (ex != 8'h00) begin
      if (!e[10]) begin
        if (e > 11'sd9) f_sat = 1'b1;
        else f_mag = mm << e[3:0];
      end else if (neg_e < 11'd26) begin
        // round half away from zero on the magnitude
        f_mag = (mm + (34'd1 << (neg_e[4:0] - 5'd1))) >> neg_e[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_tag <= '0;
    end else if (en) begin
      c1_tag <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_op    <= op_t'(op);
      c1_res   <= s1_res;
      c1_prod  <= (2*DATA_W)'(a) * (2*DATA_W)'(b);
      c1_fsign <= flt[31];
      c1_fmag  <= f_mag;
      c1_fsat  <= f_sat;
      c1_fnan  <= f_nan;
      c1_xsign <= a[DATA_W-1];
      c1_xzero <= (a == '0);
      c1_xmag  <= a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    end
  end

  // stage 2
  tag_t              c2_tag;
  logic              c2_isx;
  res_t              c2_res;
  logic              c2_xsign;
  logic              c2_xzero;
  logic [DATA_W-1:0] c2_xmag;
  logic [4:0]        c2_p;

  res_t       s2_res;
  logic       sat2;
  logic [4:0] msb;

  always_comb begin
    s2_res = c1_res;
    sat2   = c1_fsat || (!c1_fsign && c1_fmag > 34'h7FFFFFFF)
                     || (c1_fsign && c1_fmag > 34'h80000000);
    case (c1_op)
      OP_MUL: s2_res.res = c1_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
      OP_FLT2FIX: begin
        if (c1_fnan) begin
          s2_res.status = ST_SAT;
        end else if (sat2) begin
          s2_res.status = ST_SAT;
          s2_res.res    = c1_fsign ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          s2_res.res = c1_fsign ? DATA_W'(-c1_fmag[31:0]) : c1_fmag[31:0];
        end
      end
      default: s2_res = c1_res;
    endcase
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (c1_xmag[i]) msb = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_tag <= '0;
    end else if (en) begin
      c2_tag <= c1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_isx   <= (c1_op == OP_FIX2FLT);
      c2_res   <= s2_res;
      c2_xsign <= c1_xsign;
      c2_xzero <= c1_xzero;
      c2_xmag  <= c1_xmag;
      c2_p     <= msb;
    end
  end

  // stage 3: normalize to bit 31, round to nearest even
  tag_t c3_tag;
  res_t c3_res;

  res_t              s3_res;
  logic [DATA_W-1:0] norm;
  logic [23:0]       m24;
  logic              up;
  logic [24:0]       m25;
  logic [9:0]        fexp;

  always_comb begin
    norm   = c2_xmag << (5'd31 - c2_p);
    m24    = norm[31:8];
    up     = norm[7] & ((|norm[6:0]) | m24[0]);
    m25    = {1'b0, m24} + {24'd0, up};
    fexp   = {5'd0, c2_p} + {9'd0, m25[24]} + EXP_OFS;
    s3_res = c2_res;
    if (c2_isx) begin
      s3_res = '0;
      if (!c2_xzero) begin
        s3_res.fout = {c2_xsign, fexp[7:0], m25[24] ? 23'd0 : m25[22:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_tag <= '0;
    end else if (en) begin
      c3_tag <= c2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) c3_res <= s3_res;
  end

  assign tag_out = c3_tag;
  assign res_out = c3_res;

endmodule
`default_nettype wire
